@@ rtl/pect_pkg.sv @@
// package for the ear clipping triangulator: widths, payload words, status codes
// no dependencies
package pect_pkg;

  localparam int MaxVerts  = 64;
  localparam int IdxBits   = 6;
  localparam int CntBits   = 7;
  localparam int CoordBits = 16;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StTooFew   = 2'd1,
    StNoEar    = 2'd2,
    StOverflow = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] vx;
    logic signed [CoordBits-1:0] vy;
    logic                        last_vertex;
  } vert_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
    logic [1:0]                  status;
    logic                        last_triangle;
  } tri_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpStore,     // write vertex at wr index
    OpAreaClr,   // clear area sum
    OpAreaRd,    // read coords of i and j
    OpAreaAcc,   // cross-term products for the area sum
    OpAreaAdd,   // add to sum
    OpOrdWr,     // write order entry
    OpTriRd,     // reset triple coordinate select
    OpTriCo,     // read coords of a, b, c
    OpCross,     // cross product of the triple
    OpPtRd,      // read order of candidate point
    OpPtCo,      // read candidate coords
    OpPtMul,     // sub-triangle products
    OpPtSum,     // sub-triangle sums
    OpShRd,      // read order entry for shift
    OpShWr       // write shifted order entry
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [IdxBits-1:0] ia;
    logic [IdxBits-1:0] ib;
    logic [IdxBits-1:0] ic;
    logic [IdxBits-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic area_pos;
    logic cross_neg;
    logic pt_inside;
  } stat_t;

endpackage

@@ rtl/pect_datapath.sv @@
// datapath: coordinate and order memories, shoelace accumulator, ear tests
// depends on pect_pkg
module pect_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pect_pkg::cmd_t  cmd_i,
  input  pect_pkg::vert_t vert_i,
  output pect_pkg::stat_t stat_o,
  output pect_pkg::tri_t  tri_o
);
  import pect_pkg::*;

  localparam int ProdBits = 2 * CoordBits + 2;
  localparam int SumBits  = 40;

  logic [CoordBits-1:0] xmem [MaxVerts];
  logic [CoordBits-1:0] ymem [MaxVerts];
  logic [IdxBits-1:0]   omem [MaxVerts];

  // registered memory reads, two coordinate ports
  logic signed [CoordBits-1:0] x0_q, y0_q, x1_q, y1_q;
  logic [IdxBits-1:0]          o_q;
  // triple vertex ids and coordinates
  logic [IdxBits-1:0]          va_q, vb_q, vc_q;
  logic [1:0]                  tsel_q;
  logic signed [CoordBits-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [ProdBits-1:0]  p_q [6];
  logic signed [SumBits-1:0]   area_q;
  logic                        cneg_q, inside_q;

  logic [IdxBits-1:0] rd0, rd1;
  logic signed [CoordBits:0] dbx, dby, dcx, dcy;
  logic signed [CoordBits:0] ecx, ecy, fax, fay;
  logic signed [CoordBits:0] pax, pay, pbx, pby, pcx, pcy;

  always_comb begin
    rd0 = cmd_i.ia;
    rd1 = cmd_i.ib;
    case (cmd_i.op)
      OpTriCo: begin
        case (tsel_q)
          2'd0:    rd0 = va_q;
          2'd1:    rd0 = vb_q;
          default: rd0 = vc_q;
        endcase
      end
      OpPtCo:  rd0 = o_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpStore) begin
      xmem[cmd_i.ia] <= vert_i.vx;
      ymem[cmd_i.ia] <= vert_i.vy;
    end
    if (cmd_i.op == OpOrdWr) begin
      omem[cmd_i.ia] <= cmd_i.val;
    end
    // shift moves the entry read on the previous cycle
    if (cmd_i.op == OpShWr) begin
      omem[cmd_i.ia] <= o_q;
    end
    x0_q <= xmem[rd0];
    y0_q <= ymem[rd0];
    x1_q <= xmem[rd1];
    y1_q <= ymem[rd1];
    o_q  <= omem[cmd_i.ia];
  end

  assign dbx = {bx_q[CoordBits-1], bx_q} - {ax_q[CoordBits-1], ax_q};
  assign dby = {by_q[CoordBits-1], by_q} - {ay_q[CoordBits-1], ay_q};
  assign dcx = {cx_q[CoordBits-1], cx_q} - {ax_q[CoordBits-1], ax_q};
  assign dcy = {cy_q[CoordBits-1], cy_q} - {ay_q[CoordBits-1], ay_q};
  assign ecx = {cx_q[CoordBits-1], cx_q} - {bx_q[CoordBits-1], bx_q};
  assign ecy = {cy_q[CoordBits-1], cy_q} - {by_q[CoordBits-1], by_q};
  assign fax = {ax_q[CoordBits-1], ax_q} - {cx_q[CoordBits-1], cx_q};
  assign fay = {ay_q[CoordBits-1], ay_q} - {cy_q[CoordBits-1], cy_q};
  assign pax = {x0_q[CoordBits-1], x0_q} - {ax_q[CoordBits-1], ax_q};
  assign pay = {y0_q[CoordBits-1], y0_q} - {ay_q[CoordBits-1], ay_q};
  assign pbx = {x0_q[CoordBits-1], x0_q} - {bx_q[CoordBits-1], bx_q};
  assign pby = {y0_q[CoordBits-1], y0_q} - {by_q[CoordBits-1], by_q};
  assign pcx = {x0_q[CoordBits-1], x0_q} - {cx_q[CoordBits-1], cx_q};
  assign pcy = {y0_q[CoordBits-1], y0_q} - {cy_q[CoordBits-1], cy_q};

  logic signed [SumBits-1:0] s1, s2, s3;
  assign s1 = SumBits'(p_q[0]) - SumBits'(p_q[1]);
  assign s2 = SumBits'(p_q[2]) - SumBits'(p_q[3]);
  assign s3 = SumBits'(p_q[4]) - SumBits'(p_q[5]);

  // tri2(p,q,r) taken as (q-p')x(r-p') form: edge vector times point offset, split over cycles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q   <= '0;
      cneg_q   <= 1'b0;
      inside_q <= 1'b0;
      tsel_q   <= '0;
      p_q      <= '{default: '0};
      va_q     <= '0;
      vb_q     <= '0;
      vc_q     <= '0;
      ax_q     <= '0;
      ay_q     <= '0;
      bx_q     <= '0;
      by_q     <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
    end else begin
      case (cmd_i.op)
        OpAreaClr: area_q <= '0;
        OpAreaAcc: begin
          p_q[0] <= ProdBits'(x0_q * y1_q);
          p_q[1] <= ProdBits'(x1_q * y0_q);
        end
        OpAreaAdd: area_q <= area_q + SumBits'(p_q[0]) - SumBits'(p_q[1]);
        OpTriRd: begin
          tsel_q <= '0;
        end
        OpTriCo: begin
          case (cmd_i.val[1:0])
            2'd1:    begin va_q <= o_q; tsel_q <= 2'd0; end
            2'd2:    begin vb_q <= o_q; tsel_q <= 2'd1; end
            2'd3:    begin vc_q <= o_q; tsel_q <= 2'd2; end
            default: ;
          endcase
          case (cmd_i.ic[1:0])
            2'd1:    begin ax_q <= x0_q; ay_q <= y0_q; end
            2'd2:    begin bx_q <= x0_q; by_q <= y0_q; end
            2'd3:    begin cx_q <= x0_q; cy_q <= y0_q; end
            default: ;
          endcase
        end
        OpCross: begin
          p_q[0] <= ProdBits'(dbx * dcy);
          p_q[1] <= ProdBits'(dby * dcx);
        end
        OpPtMul: begin
          p_q[0] <= ProdBits'(dbx * pay);
          p_q[1] <= ProdBits'(dby * pax);
          p_q[2] <= ProdBits'(ecx * pby);
          p_q[3] <= ProdBits'(ecy * pbx);
          p_q[4] <= ProdBits'(fax * pcy);
          p_q[5] <= ProdBits'(fay * pcx);
        end
        OpPtSum: begin
          inside_q <= ((s1 > 0) && (s2 > 0) && (s3 > 0)) ||
                      (!(s1 > 0) && !(s2 > 0) && !(s3 > 0));
        end
        default: ;
      endcase
      if (cmd_i.op == OpTriCo && cmd_i.ic[1:0] == 2'd0) begin
        cneg_q <= 1'b0;
      end
      if (cmd_i.op == OpPtMul && cmd_i.ic[1:0] == 2'd1) begin
        cneg_q <= (SumBits'(p_q[0]) - SumBits'(p_q[1])) < 0;
      end
    end
  end

  assign stat_o.area_pos  = area_q > 0;
  assign stat_o.cross_neg = cneg_q;
  assign stat_o.pt_inside = inside_q;

  assign tri_o.ax = ax_q;
  assign tri_o.ay = ay_q;
  assign tri_o.bx = bx_q;
  assign tri_o.by = by_q;
  assign tri_o.cx = cx_q;
  assign tri_o.cy = cy_q;
  assign tri_o.status = StOk;
  assign tri_o.last_triangle = 1'b0;

endmodule

@@ rtl/pect_ctrl.sv @@
// controller: load, orientation, ear scan sequencing and result strobe
// depends on pect_pkg
module pect_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pect_pkg::vert_t vert_i,
  input  pect_pkg::stat_t stat_i,
  input  pect_pkg::tri_t  tri_i,
  output pect_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            done_o,
  output pect_pkg::tri_t  res_o
);
  import pect_pkg::*;

  typedef enum logic [4:0] {
    SIdle, SAreaRd, SAreaW1, SAreaMul, SAreaAdd, SOrd, STri, STriCo, SCross,
    SCrossW, SCrossChk, SPt, SPtCo, SPtMul, SPtSum, SPtChk, SEmit, SShift,
    SShiftW, SErr
  } state_e;

  state_e state_q;
  logic [CntBits-1:0] n_q, i_q, fail_q;
  logic [IdxBits-1:0] a_q, b_q, c_q, scan_q;
  logic [2:0]         k_q;
  logic               ovf_q;
  status_e            err_q;
  tri_t               res_q;
  logic               done_q;
  logic [CntBits-1:0] j_w, b1, c1, n1;

  assign busy_o = (state_q != SIdle);
  assign done_o = done_q;
  assign res_o  = res_q;

  assign j_w = (i_q + 1'b1 == n_q) ? '0 : i_q + 1'b1;
  assign n1  = n_q - 1'b1;
  assign b1  = ({1'b0, a_q} + 1'b1 >= n_q) ? '0 : {1'b0, a_q} + 1'b1;
  assign c1  = (b1 + 1'b1 >= n_q) ? '0 : b1 + 1'b1;

  always_comb begin
    cmd_o = '{op: OpNone, ia: '0, ib: '0, ic: '0, val: '0};
    case (state_q)
      SIdle: if (start_i) cmd_o = '{op: (n_q < CntBits'(MaxVerts)) ? OpStore : OpNone,
                                    ia: n_q[IdxBits-1:0], ib: '0, ic: '0, val: '0};
      SAreaRd:  cmd_o = '{op: OpAreaRd, ia: i_q[IdxBits-1:0], ib: j_w[IdxBits-1:0],
                          ic: '0, val: '0};
      SAreaMul: cmd_o.op = OpAreaAcc;
      SAreaAdd: cmd_o.op = OpAreaAdd;
      SOrd: cmd_o = '{op: OpOrdWr, ia: i_q[IdxBits-1:0], ib: '0, ic: '0,
                      val: stat_i.area_pos ? i_q[IdxBits-1:0] : IdxBits'(n1 - i_q)};
      SCrossChk: cmd_o.op = OpAreaClr;
      // order read for slot k, coords of the previous slot in flight
      STri: cmd_o = '{op: OpTriCo,
                      ia: (k_q == 3'd0) ? a_q : (k_q == 3'd1) ? b_q : c_q,
                      ib: '0, ic: '0, val: '0};
      STriCo: cmd_o = '{op: OpTriCo, ia: '0, ib: '0, ic: k_q[1:0],
                        val: (k_q == 3'd3) ? '0 : IdxBits'(k_q + 3'd1)};
      SCross: cmd_o.op = OpCross;
      SCrossW: cmd_o = '{op: OpPtMul, ia: '0, ib: '0, ic: 2'd1, val: '0};
      SPt:   cmd_o = '{op: OpPtRd, ia: i_q[IdxBits-1:0], ib: '0, ic: '0, val: '0};
      SPtCo: cmd_o.op = OpPtCo;
      SPtMul: cmd_o.op = OpPtMul;
      SPtSum: cmd_o.op = OpPtSum;
      SShift: cmd_o = '{op: OpShRd, ia: IdxBits'(i_q + 1'b1), ib: '0, ic: '0, val: '0};
      SShiftW: cmd_o = '{op: OpShWr, ia: i_q[IdxBits-1:0], ib: '0, ic: '0,
                         val: '0};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      n_q <= '0; i_q <= '0; fail_q <= '0; a_q <= '0; b_q <= '0; c_q <= '0;
      scan_q <= '0; k_q <= '0; ovf_q <= 1'b0; err_q <= StOk; done_q <= 1'b0;
      res_q <= '0;
    end else begin
      done_q <= (state_q == SEmit) || (state_q == SErr);
      case (state_q)
        SIdle: if (start_i) begin
          if (n_q < CntBits'(MaxVerts)) n_q <= n_q + 1'b1;
          else ovf_q <= 1'b1;
          if (vert_i.last_vertex) begin
            if (ovf_q || n_q >= CntBits'(MaxVerts)) begin
              err_q <= StOverflow; state_q <= SErr;
            end else if (n_q + 1'b1 < CntBits'(3)) begin
              err_q <= StTooFew; state_q <= SErr;
            end else begin
              i_q <= '0; state_q <= SAreaRd;
            end
          end
        end
        SAreaRd:  state_q <= SAreaMul;
        SAreaMul: state_q <= SAreaAdd;
        SAreaAdd: begin
          if (i_q == n1) begin i_q <= '0; state_q <= SOrd; end
          else begin i_q <= i_q + 1'b1; state_q <= SAreaRd; end
        end
        SOrd: begin
          if (i_q == n1) begin
            scan_q <= '0; fail_q <= '0; state_q <= SCrossChk;
            k_q <= 3'd7;
          end else i_q <= i_q + 1'b1;
        end
        SCrossChk: begin
          // start next triple
          a_q <= ({1'b0, scan_q} >= n_q) ? '0 : scan_q;
          k_q <= '0; state_q <= STri;
        end
        STri: begin
          if (k_q == 3'd0) begin
            b_q <= b1[IdxBits-1:0]; c_q <= c1[IdxBits-1:0];
            scan_q <= b1[IdxBits-1:0];
          end
          state_q <= STriCo;
        end
        STriCo: begin
          if (k_q == 3'd3) state_q <= SCross;
          else begin k_q <= k_q + 1'b1; state_q <= STri; end
        end
        SCross:  state_q <= SCrossW;
        SCrossW: begin
          i_q <= '0; state_q <= SPtChk;
          k_q <= 3'd1;
        end
        SPt:    state_q <= SPtCo;
        SPtCo:  state_q <= SPtMul;
        SPtMul: state_q <= SPtSum;
        SPtSum: begin k_q <= '0; state_q <= SPtChk; end
        SPtChk: begin
          if ((k_q == 3'd1 && stat_i.cross_neg) ||
              (k_q == 3'd0 && stat_i.pt_inside)) begin
            // not an ear
            if (fail_q + 1'b1 >= n_q) begin
              err_q <= StNoEar; state_q <= SErr;
            end else begin
              fail_q <= fail_q + 1'b1; state_q <= SCrossChk;
            end
          end else begin
            logic [CntBits-1:0] nx;
            nx = (k_q == 3'd1) ? i_q : i_q + 1'b1;
            if (nx == {1'b0, a_q} || nx == {1'b0, b_q} || nx == {1'b0, c_q})
              nx = nx + 1'b1;
            if (nx == {1'b0, a_q} || nx == {1'b0, b_q} || nx == {1'b0, c_q})
              nx = nx + 1'b1;
            if (nx == {1'b0, a_q} || nx == {1'b0, b_q} || nx == {1'b0, c_q})
              nx = nx + 1'b1;
            if (nx >= n_q) state_q <= SEmit;
            else begin i_q <= nx; state_q <= SPt; end
          end
        end
        SEmit: begin
          res_q <= '{ax: tri_i.ax, ay: tri_i.ay, bx: tri_i.bx, by: tri_i.by,
                     cx: tri_i.cx, cy: tri_i.cy, status: StOk,
                     last_triangle: (n_q == CntBits'(3))};
          fail_q <= '0;
          i_q <= {1'b0, b_q};
          if (n_q == CntBits'(3)) begin
            n_q <= '0; ovf_q <= 1'b0; state_q <= SIdle;
          end else if ({1'b0, b_q} + 1'b1 >= n_q) begin
            n_q <= n1; state_q <= SCrossChk;
          end else state_q <= SShift;
        end
        SShift: state_q <= SShiftW;
        SShiftW: begin
          if (i_q + 2'd2 >= n_q) begin n_q <= n1; state_q <= SCrossChk; end
          else begin i_q <= i_q + 1'b1; state_q <= SShift; end
        end
        SErr: begin
          res_q <= '{status: err_q, last_triangle: 1'b1, default: '0};
          n_q <= '0; ovf_q <= 1'b0; state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

@@ rtl/polygon_ear_clip_triangulator.sv @@
// top level of the ear clipping triangulator
// depends on pect_pkg, pect_ctrl, pect_datapath
//
// Vertices are taken one word per cycle while busy is low. The word marked
// last_vertex starts triangulation and raises busy until the final result
// word. Results appear for one cycle each with valid_o high; the receiver cannot
// stall and must take them as they come. Run time is set by the single shared
// ear-test unit: an orientation pass over all vertices, then per candidate
// triple a cross test plus a point test for each other live vertex, and per
// cut a shift of every order entry after the removed vertex.
module polygon_ear_clip_triangulator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  pect_pkg::vert_t vert_i,
  output logic            valid_o,
  output pect_pkg::tri_t  tri_o
);
  import pect_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  tri_t  dp_tri;

  pect_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .vert_i, .stat_i(stat), .tri_i(dp_tri),
    .cmd_o(cmd), .busy_o(busy), .done_o(valid_o), .res_o(tri_o)
  );

  pect_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .vert_i, .stat_o(stat), .tri_o(dp_tri)
  );

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && tri_o.status != StOk |-> tri_o.last_triangle && tri_o.ax == '0)
    else $error("error word carries data");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && tri_o.last_triangle |-> !busy)
    else $error("busy after final word");
  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !$past(busy) |-> !valid_o)
    else $error("result while idle");

endmodule

@@ bench/tb_polygon_ear_clip_triangulator.sv @@
// testbench for polygon_ear_clip_triangulator: drives vertex words, predicts triangles
// depends on pect_pkg and the rtl top level; a scoreboard class holds the expected words
module tb_polygon_ear_clip_triangulator;
  import pect_pkg::*;

  localparam int WatchLimit = 2000000;

  class tri_scoreboard;
    tri_t pending_q[$];
    int   errors;
    int   checked;
    longint px[64];
    longint py[64];
    int   nverts;
    bit   ovf;

    function longint area2(longint ax, longint ay, longint bx, longint by,
                           longint cx, longint cy);
      return (ax * by - bx * ay) + (bx * cy - cx * by) + (cx * ay - ax * cy);
    endfunction

    function void add_word(tri_t t);
      pending_q = {pending_q, t};
    endfunction

    function void push_err(status_e st);
      tri_t t;
      t = '0;
      t.status = st;
      t.last_triangle = 1'b1;
      add_word(t);
    endfunction

    // takes one accepted vertex word, queues the result words it produces
    function void note_vertex(vert_t v);
      int     n, a, b, c, fails, scan, q, ord[64];
      longint s, cr;
      bit     ear, s1, s2, s3;
      tri_t   t;
      if (nverts < MaxVerts) begin
        px[nverts] = v.vx;
        py[nverts] = v.vy;
        nverts++;
      end else begin
        ovf = 1;
      end
      if (!v.last_vertex) return;
      n = nverts;
      if (ovf) push_err(StOverflow);
      else if (n < 3) push_err(StTooFew);
      else begin
        s = 0;
        for (int i = 0; i < n; i++) begin
          q = (i + 1 == n) ? 0 : i + 1;
          s += px[i] * py[q] - px[q] * py[i];
        end
        for (int i = 0; i < n; i++) ord[i] = (s > 0) ? i : n - 1 - i;
        scan = 0;
        fails = 0;
        while (n > 2) begin
          a = (scan >= n) ? 0 : scan;
          b = (a + 1 >= n) ? 0 : a + 1;
          c = (b + 1 >= n) ? 0 : b + 1;
          scan = b;
          cr = (px[ord[b]] - px[ord[a]]) * (py[ord[c]] - py[ord[a]])
             - (py[ord[b]] - py[ord[a]]) * (px[ord[c]] - px[ord[a]]);
          ear = (cr >= 0);
          for (int i = 0; i < n && ear; i++) begin
            if (i == a || i == b || i == c) continue;
            q = ord[i];
            s1 = area2(px[q], py[q], px[ord[a]], py[ord[a]], px[ord[b]], py[ord[b]]) > 0;
            s2 = area2(px[q], py[q], px[ord[b]], py[ord[b]], px[ord[c]], py[ord[c]]) > 0;
            s3 = area2(px[q], py[q], px[ord[c]], py[ord[c]], px[ord[a]], py[ord[a]]) > 0;
            if ((s1 && s2 && s3) || (!s1 && !s2 && !s3)) ear = 0;
          end
          if (ear) begin
            t.ax = CoordBits'(px[ord[a]]); t.ay = CoordBits'(py[ord[a]]);
            t.bx = CoordBits'(px[ord[b]]); t.by = CoordBits'(py[ord[b]]);
            t.cx = CoordBits'(px[ord[c]]); t.cy = CoordBits'(py[ord[c]]);
            t.status = StOk;
            t.last_triangle = (n == 3);
            add_word(t);
            for (int i = b; i + 1 < n; i++) ord[i] = ord[i + 1];
            n--;
            fails = 0;
          end else begin
            fails++;
            if (fails >= n) begin
              push_err(StNoEar);
              break;
            end
          end
        end
      end
      nverts = 0;
      ovf = 0;
    endfunction

    task check_word(tri_t got);
      tri_t w;
      checked++;
      if (pending_q.size() == 0) begin
        report("unexpected word", got, '0);
        return;
      end
      w = pending_q.pop_front();
      if (got.ax !== w.ax) report("ax", got, w);
      if (got.ay !== w.ay) report("ay", got, w);
      if (got.bx !== w.bx) report("bx", got, w);
      if (got.by !== w.by) report("by", got, w);
      if (got.cx !== w.cx) report("cx", got, w);
      if (got.cy !== w.cy) report("cy", got, w);
      if (got.status !== w.status) report("status", got, w);
      if (got.last_triangle !== w.last_triangle) report("last_triangle", got, w);
    endtask

    task report(string what, tri_t got, tri_t want);
      errors++;
      $display("mismatch %s: got %h want %h", what, got, want);
    endtask
  endclass

  logic  clk_i, rst_ni, start, busy, valid_o;
  vert_t vert_i;
  tri_t  tri_o;
  tri_scoreboard sb;
  int    idle_cycles = 0;
  int    sent;
  int    polys;

  polygon_ear_clip_triangulator u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .vert_i(vert_i), .valid_o(valid_o), .tri_o(tri_o)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check_word(tri_o);
      if ((start && !busy) || valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) sb.note_vertex(vert_i);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired");
      $display("** polygon_ear_clip_triangulator: FAILED **");
      $finish;
    end
  end

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(negedge clk_i);
  endtask

  // one vertex word, held until accepted
  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, bit lst);
    vert_i.vx = x;
    vert_i.vy = y;
    vert_i.last_vertex = lst;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    start = 1'b0;
    sent++;
    if (lst) polys++;
    idle_gap();
  endtask

  // convex n-gon around the origin with radius r, counterclockwise or not
  task automatic send_ngon(int n, real r, bit ccw);
    real ang;
    for (int i = 0; i < n; i++) begin
      ang = 6.2831853 * i / n * (ccw ? 1.0 : -1.0);
      send_vertex(16'($rtoi(r * $cos(ang))), 16'($rtoi(r * $sin(ang))), i == n - 1);
    end
  endtask

  task automatic send_random_poly(int n, int span);
    for (int i = 0; i < n; i++)
      send_vertex(16'(int'($urandom_range(0, 2 * span)) - span),
                  16'(int'($urandom_range(0, 2 * span)) - span),
                  i == n - 1);
  endtask

  initial begin
    sb = new();
    start = 0;
    vert_i = '0;
    rst_ni = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed: too few, extremes, both orientations, concave, degenerate
    send_vertex(16'sh7fff, -16'sh8000, 1);
    send_vertex(-16'sh8000, 16'sh7fff, 0);
    send_vertex(16'sh7fff, 16'sh7fff, 1);
    send_vertex(-16'sh8000, -16'sh8000, 0);
    send_vertex(16'sh7fff, -16'sh8000, 0);
    send_vertex(16'sh7fff, 16'sh7fff, 1);
    send_ngon(4, 30000.0, 0);
    send_vertex(0, 0, 0);
    send_vertex(20000, 0, 0);
    send_vertex(20000, 20000, 0);
    send_vertex(10000, 2000, 0);
    send_vertex(0, 20000, 1);
    send_vertex(100, 100, 0);
    send_vertex(100, 100, 0);
    send_vertex(100, 100, 1);
    // overflow: 65 vertices in one polygon
    for (int i = 0; i < 65; i++)
      send_vertex(16'($urandom), 16'($urandom), i == 64);
    // random: mostly convex polygons with small counts, some noise shapes
    while (sent < 85) begin
      if ($urandom_range(0, 3) != 0)
        send_ngon($urandom_range(3, 9), $urandom_range(1000, 32000), $urandom_range(0, 1));
      else
        send_random_poly($urandom_range(1, 7), $urandom_range(0, 1) ? 32767 : 200);
    end
    send_ngon(20, 32000.0, 1);
    send_vertex(16'sh1234, -16'sh1234, 0);
    send_vertex(-16'sh5555, 16'sh2aaa, 1);
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("sent %0d vertex words in %0d polygons, checked %0d result words",
             sent, polys, sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("** polygon_ear_clip_triangulator: PASSED **");
    end else begin
      $display("** polygon_ear_clip_triangulator: FAILED **");
    end
    $finish;
  end

endmodule
